[design/mcc_pkg.sv]
// Package: shared constants and types for the multichannel convolution layer.
package mcc_pkg;
   localparam int IMG_W_DEF       = 32;
   localparam int IMG_H_DEF       = 32;
   localparam int KERNEL_DEF      = 5;
   localparam int CHANNELS_DEF    = 3;
   localparam int NUM_FILTERS_DEF = 32;
   localparam int PIX_W           = 16;
   localparam int WGT_W           = 16;
   localparam int BIAS_W          = 32;
   localparam int ACC_W           = 64;
   localparam int OUT_W           = 32;
   localparam logic [4:0] SHIFT_RESET = 5'd14;

   typedef enum logic [1:0] {
      CMD_WEIGHT = 2'd0,
      CMD_BIAS   = 2'd1,
      CMD_PIXEL  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [4:0]        filter_idx;
      logic [1:0]        chan_idx;
      logic [2:0]        tap_row;
      logic [2:0]        tap_col;
      logic signed [15:0] weight_value;
      logic signed [31:0] bias_value;
      logic signed [15:0] pix_c0;
      logic signed [15:0] pix_c1;
      logic signed [15:0] pix_c2;
   } req_type;

   typedef struct packed {
      logic [4:0]         out_filter;
      logic [4:0]         out_row;
      logic [4:0]         out_col;
      logic signed [31:0] conv_value;
      logic               last_filter;
      logic               last_of_image;
   } rsp_type;

   // control handed to the multiply-accumulate unit with each product
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;
endpackage

[design/mcc_if.sv]
// Interfaces: valid/ready channels for requests and results.
interface mcc_req_if;
   import mcc_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mcc_rsp_if;
   import mcc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[design/mcc_cell.sv]
// Window cell: one tap of the shift window, feeds its left-hand neighbor.
module mcc_cell #(
   parameter int CHANNELS = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              shift,
   input  logic [CHANNELS*mcc_pkg::PIX_W-1:0] in_data,
   output logic [CHANNELS*mcc_pkg::PIX_W-1:0] out_data
);
   import mcc_pkg::*;
   logic [CHANNELS*PIX_W-1:0] tap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else if (shift) begin
         tap_ff <= in_data;
      end
   end
   assign out_data = tap_ff;
endmodule

[design/mcc_mac.sv]
// Multiply-accumulate unit: registered product, then 64-bit accumulation.
module mcc_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  mcc_pkg::mac_ctl_type              ctl,
   input  logic signed [mcc_pkg::PIX_W-1:0]  pix,
   input  logic signed [mcc_pkg::WGT_W-1:0]  wgt,
   input  logic signed [mcc_pkg::BIAS_W-1:0] bias,
   output logic                              done,
   output logic signed [mcc_pkg::ACC_W-1:0]  acc
);
   import mcc_pkg::*;
   mac_ctl_type              ctl_ff;
   logic signed [31:0]       prod_ff;
   logic signed [BIAS_W-1:0] bias_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl_ff  <= ctl;
         done_ff <= ctl_ff.valid & ctl_ff.last;
      end
      prod_ff <= pix * wgt;
      bias_ff <= bias;
      if (ctl_ff.valid) begin
         if (ctl_ff.first) begin
            acc_ff <= ACC_W'(bias_ff) + ACC_W'(prod_ff);
         end else begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end
   assign done = done_ff;
   assign acc  = acc_ff;
endmodule

[design/multichannel_conv2d_layer.sv]
// Top level: multichannel valid-mode 5x5 convolution layer with bias.
//
//  channel | dir | handshake       | carries
//  req     | in  | valid/ready     | load weight, load bias, pixel
//  rsp     | out | valid/ready     | one filter result per transfer
//  csr     | in  | write enable    | out_shift
//
// A load is written to its memory as it is taken, and a pixel is shifted into
// the window as it is taken; a pixel that completes an output window then
// runs every filter through one shared multiply-accumulate unit, one tap a
// cycle within each filter's run.
// Results go out through a one-entry output register; a stalled rsp holds
// the sequencer. Synchronous reset clears window, line store and counters;
// the line store is cleared by a pass over its IMG_W columns after reset,
// during which no req transfer is taken.
module multichannel_conv2d_layer #(
   parameter int IMG_W       = mcc_pkg::IMG_W_DEF,
   parameter int IMG_H       = mcc_pkg::IMG_H_DEF,
   parameter int KERNEL      = mcc_pkg::KERNEL_DEF,
   parameter int CHANNELS    = mcc_pkg::CHANNELS_DEF,
   parameter int NUM_FILTERS = mcc_pkg::NUM_FILTERS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mcc_req_if.sink    req,
   mcc_rsp_if.source  rsp,
   input  logic       csr_we,
   input  logic [4:0] csr_wdata
);
   import mcc_pkg::*;

   localparam int TAPS  = KERNEL * KERNEL;
   localparam int NMAC  = CHANNELS * TAPS;
   localparam int WDEP  = NUM_FILTERS * NMAC;
   localparam int WAW   = $clog2(WDEP);
   localparam int FW    = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
   localparam int MW    = (NMAC > 1) ? $clog2(NMAC) : 1;
   localparam int XW    = $clog2(IMG_W);
   localparam int YW    = $clog2(IMG_H);
   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int TW    = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int LROWS = (KERNEL > 1) ? KERNEL - 1 : 1;
   localparam int PXW   = CHANNELS * PIX_W;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_RUN, ST_DRAIN, ST_WAIT
   } state_type;

   // ---------------- storage ----------------
   logic signed [WGT_W-1:0]  wmem [WDEP];
   logic signed [BIAS_W-1:0] bmem [NUM_FILTERS];
   logic [LROWS*PXW-1:0]     lmem [IMG_W];

   state_type        state_ff;
   logic [4:0]       shift_ff;
   logic [XW-1:0]    col_ff;
   logic [YW-1:0]    row_ff;
   logic [XW-1:0]    clr_ff;
   logic [FW-1:0]    filt_ff;
   logic [MW-1:0]    tap_ff;
   logic [4:0]       orow_ff, ocol_ff;
   logic             img_end_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic                    mac_done;
   logic signed [ACC_W-1:0] acc;
   logic signed [OUT_W-1:0] sat_val;

   always_ff @(posedge clock) begin
      if (reset) shift_ff <= SHIFT_RESET;
      else if (csr_we) shift_ff <= csr_wdata;
   end

   // ---------------- input decode ----------------
   req_type   rq;
   logic      req_xfer;
   logic [PXW-1:0] pix_vec;
   assign rq       = req.data;
   assign req.ready = (state_ff == ST_IDLE);
   assign req_xfer = req.valid & req.ready;

   always_comb begin
      pix_vec = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         case (c)
            0: pix_vec[c*PIX_W +: PIX_W] = rq.pix_c0;
            1: pix_vec[c*PIX_W +: PIX_W] = rq.pix_c1;
            2: pix_vec[c*PIX_W +: PIX_W] = rq.pix_c2;
            default: pix_vec[c*PIX_W +: PIX_W] = '0;
         endcase
      end
   end

   logic is_pix, fires;
   assign is_pix = req_xfer && (rq.cmd == CMD_PIXEL);
   assign fires  = (32'(row_ff) >= KERNEL - 1) && (32'(col_ff) >= KERNEL - 1);

   // weight address of a load
   logic w_ok;
   logic [WAW-1:0] w_addr;
   assign w_ok = (32'(rq.filter_idx) < NUM_FILTERS) && (32'(rq.chan_idx) < CHANNELS)
              && (32'(rq.tap_row) < KERNEL) && (32'(rq.tap_col) < KERNEL);
   assign w_addr = WAW'(((32'(rq.filter_idx) * CHANNELS + 32'(rq.chan_idx)) * KERNEL
                   + 32'(rq.tap_row)) * KERNEL + 32'(rq.tap_col));

   always_ff @(posedge clock) begin
      if (req_xfer && rq.cmd == CMD_WEIGHT && w_ok) wmem[w_addr] <= rq.weight_value;
      if (req_xfer && rq.cmd == CMD_BIAS && 32'(rq.filter_idx) < NUM_FILTERS)
         bmem[FW'(rq.filter_idx)] <= rq.bias_value;
   end

   // ---------------- line store ----------------
   // column read combinationally is avoided: read address is col_ff, which
   // advances with the pixel, so a registered prefetch of the next column
   // is kept in lrd_ff.
   logic [LROWS*PXW-1:0] lrd_ff, lwr;
   logic [XW-1:0] col_nx;
   assign col_nx = (32'(col_ff) == IMG_W - 1) ? '0 : col_ff + 1'b1;

   always_comb begin
      lwr = '0;
      if (KERNEL > 1) begin
         for (int r = 0; r + 1 < LROWS; r++) lwr[r*PXW +: PXW] = lrd_ff[(r+1)*PXW +: PXW];
         lwr[(LROWS-1)*PXW +: PXW] = pix_vec;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) lmem[clr_ff] <= '0;
      else if (is_pix) lmem[col_ff] <= lwr;
      if (is_pix) lrd_ff <= (col_nx == col_ff) ? lwr : lmem[col_nx];
      else if (state_ff == ST_CLEAR) lrd_ff <= '0;
   end

   // incoming column: stored rows on top, new pixel at the bottom
   logic [KERNEL*PXW-1:0] column;
   always_comb begin
      column = '0;
      if (KERNEL > 1) begin
         for (int r = 0; r < LROWS; r++) column[r*PXW +: PXW] = lrd_ff[r*PXW +: PXW];
      end
      column[(KERNEL-1)*PXW +: PXW] = pix_vec;
   end

   // ---------------- window: chain of cells ----------------
   // cell index r*KERNEL+c; new data enters at c = KERNEL-1, shifts left.
   // During a run the whole window also rotates one tap per cycle so the
   // tap under the MAC is always cell 0 of channel view below.
   logic [PXW-1:0] cell_q [TAPS];
   logic [PXW-1:0] cell_d [TAPS];
   logic           wshift;
   logic           rotate;
   assign rotate = (state_ff == ST_RUN) || (state_ff == ST_DRAIN && 1'b0);
   assign wshift = is_pix || rotate;

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         if (rotate) begin
            cell_d[i] = cell_q[(i + 1) % TAPS];
         end else if ((i % KERNEL) == KERNEL - 1) begin
            cell_d[i] = column[(i / KERNEL)*PXW +: PXW];
         end else begin
            cell_d[i] = cell_q[(i + 1) % TAPS];
         end
      end
   end

   for (genvar g = 0; g < TAPS; g++) begin : g_cell
      mcc_cell #(.CHANNELS(CHANNELS)) u_cell (
         .clock(clock), .reset(reset), .shift(wshift),
         .in_data(cell_d[g]), .out_data(cell_q[g])
      );
   end

   // ---------------- sequencer ----------------
   // tap_ff counts channel-major: ch = tap / TAPS, window tap = tap % TAPS.
   // The window rotates once per tap of a channel and so returns to place
   // after each channel pass, i.e. TAPS rotations per channel.
   logic [CW-1:0] ch_ff;
   logic [TW-1:0] wt_ff;
   logic          last_tap;
   assign last_tap = (32'(tap_ff) == NMAC - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         filt_ff      <= '0;
         tap_ff       <= '0;
         ch_ff        <= '0;
         wt_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_WAIT the result register load below decides valid
         if (rsp_valid_ff && rsp.ready && state_ff != ST_WAIT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == IMG_W - 1) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (is_pix) begin
                  orow_ff    <= 5'(32'(row_ff) - (KERNEL - 1));
                  ocol_ff    <= 5'(32'(col_ff) - (KERNEL - 1));
                  img_end_ff <= (32'(row_ff) == IMG_H - 1) && (32'(col_ff) == IMG_W - 1);
                  col_ff     <= col_nx;
                  if (32'(col_ff) == IMG_W - 1) begin
                     row_ff <= (32'(row_ff) == IMG_H - 1) ? '0 : row_ff + 1'b1;
                  end
                  if (fires) begin
                     state_ff <= ST_RUN;
                     filt_ff  <= '0;
                     tap_ff   <= '0;
                     ch_ff    <= '0;
                     wt_ff    <= '0;
                  end
               end
            end
            ST_RUN: begin
               tap_ff <= last_tap ? '0 : tap_ff + 1'b1;
               if (32'(wt_ff) == TAPS - 1) begin
                  wt_ff <= '0;
                  ch_ff <= ch_ff + 1'b1;
               end else begin
                  wt_ff <= wt_ff + 1'b1;
               end
               if (last_tap) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               if (mac_done) state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.out_filter    <= 5'(filt_ff);
                  rsp_data_ff.out_row       <= orow_ff;
                  rsp_data_ff.out_col       <= ocol_ff;
                  rsp_data_ff.conv_value    <= sat_val;
                  rsp_data_ff.last_filter   <= (32'(filt_ff) == NUM_FILTERS - 1);
                  rsp_data_ff.last_of_image <= img_end_ff && (32'(filt_ff) == NUM_FILTERS - 1);
                  if (32'(filt_ff) == NUM_FILTERS - 1) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     filt_ff  <= filt_ff + 1'b1;
                     tap_ff   <= '0;
                     ch_ff    <= '0;
                     wt_ff    <= '0;
                     state_ff <= ST_RUN;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ---------------- operand fetch (registered memory read) ----------------
   logic signed [WGT_W-1:0]  wrd_ff;
   logic signed [PIX_W-1:0]  prd_ff;
   logic signed [BIAS_W-1:0] brd_ff;
   mac_ctl_type              fctl_ff;
   logic [WAW-1:0]           r_addr;
   assign r_addr = WAW'(32'(filt_ff) * NMAC + 32'(tap_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         fctl_ff <= '0;
      end else begin
         fctl_ff.valid <= (state_ff == ST_RUN);
         fctl_ff.first <= (tap_ff == '0);
         fctl_ff.last  <= last_tap;
      end
      wrd_ff <= wmem[r_addr];
      brd_ff <= bmem[filt_ff];
      prd_ff <= cell_q[0][32'(ch_ff)*PIX_W +: PIX_W];
   end

   mcc_mac u_mac (
      .clock(clock), .reset(reset), .ctl(fctl_ff),
      .pix(prd_ff), .wgt(wrd_ff), .bias(brd_ff),
      .done(mac_done), .acc(acc)
   );

   // floor shift then saturate; value is held until the result register loads
   logic signed [ACC_W-1:0] shifted;
   assign shifted = acc >>> shift_ff;
   always_comb begin
      if (shifted > ACC_W'(64'sd2147483647))       sat_val = 32'sh7fffffff;
      else if (shifted < -ACC_W'(64'sd2147483648)) sat_val = 32'sh80000000;
      else                                         sat_val = OUT_W'(shifted);
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;
endmodule

[design/mcc_checker.sv]
// Checker: port-level properties of the convolution layer, bound to the top.
module mcc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mcc_pkg::rsp_type rsp_data
);
   import mcc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_no_req_in_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req ready right after reset");

   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_filter |-> !req_ready)
      else $error("req taken mid position");

   a_img_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_image |-> rsp_data.last_filter)
      else $error("image end not on last filter");
endmodule

bind multichannel_conv2d_layer mcc_checker u_mcc_checker (
   .clock(clock), .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

[tb/multichannel_conv2d_layer_tb.sv]
// Testbench: checks the convolution layer against a built-in predictor.
`timescale 1ns / 100ps

module multichannel_conv2d_layer_tb;
   import mcc_pkg::*;

   // Image geometry as the block's defaults.
   localparam int IW = IMG_W_DEF;
   localparam int IH = IMG_H_DEF;
   localparam int K  = KERNEL_DEF;
   localparam int CH = CHANNELS_DEF;
   localparam int NF = NUM_FILTERS_DEF;
   localparam int WATCH_LIMIT = 20000;
   localparam int SETTLE = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic [4:0] csr_wdata = '0;

   mcc_req_if req ();
   mcc_rsp_if rsp ();

   multichannel_conv2d_layer #(
      .IMG_W(IW), .IMG_H(IH), .KERNEL(K), .CHANNELS(CH), .NUM_FILTERS(NF)
   ) u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // ---- predictor state ----
   logic signed [15:0] wgt_mem  [NF][CH][K][K];
   logic signed [31:0] bias_mem [NF];
   logic signed [15:0] line_mem [K-1][IW][CH];
   logic signed [15:0] win      [K][K][CH];
   int                 row_cnt, col_cnt;
   logic [4:0]         shift_amt;

   rsp_type pending_results[$];
   int      err_count = 0;
   int      send_idle = 0;   // percent of cycles the sender holds off
   int      rsp_stall = 0;   // percent of cycles the receiver stalls

   initial begin
      req.valid = 1'b0;
      req.data  = '0;
      rsp.ready = 1'b0;
   end

   // Weight and bias loads update the model stores; a pixel shifts into the line
   // store and window and, when the window completes, queues one result per filter.
   task automatic conv_model_step(input req_type it);
      logic signed [15:0] column [K];
      logic signed [15:0] px;
      longint acc;
      rsp_type r;
      case (cmd_type'(it.cmd))
         CMD_WEIGHT: begin
            if (it.chan_idx < CH && it.tap_row < K && it.tap_col < K)
               wgt_mem[it.filter_idx][it.chan_idx][it.tap_row][it.tap_col] = it.weight_value;
         end
         CMD_BIAS: bias_mem[it.filter_idx] = it.bias_value;
         CMD_PIXEL: begin
            for (int c = 0; c < CH; c++) begin
               px = (c == 0) ? it.pix_c0 : (c == 1) ? it.pix_c1 : it.pix_c2;
               for (int y = 0; y < K-1; y++) column[y] = line_mem[y][col_cnt][c];
               column[K-1] = px;
               for (int y = 0; y < K-2; y++) line_mem[y][col_cnt][c] = line_mem[y+1][col_cnt][c];
               line_mem[K-2][col_cnt][c] = px;
               for (int y = 0; y < K; y++) begin
                  for (int x = 0; x < K-1; x++) win[y][x][c] = win[y][x+1][c];
                  win[y][K-1][c] = column[y];
               end
            end
            if (row_cnt >= K-1 && col_cnt >= K-1) begin
               for (int f = 0; f < NF; f++) begin
                  acc = longint'(bias_mem[f]);
                  for (int c = 0; c < CH; c++)
                     for (int y = 0; y < K; y++)
                        for (int x = 0; x < K; x++)
                           acc += longint'(win[y][x][c]) * longint'(wgt_mem[f][c][y][x]);
                  acc = acc >>> shift_amt;   // floor shift
                  if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                  if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                  r.out_filter    = 5'(f);
                  r.out_row       = 5'(row_cnt - (K-1));
                  r.out_col       = 5'(col_cnt - (K-1));
                  r.conv_value    = acc[31:0];
                  r.last_filter   = (f == NF-1);
                  r.last_of_image = (f == NF-1) && (row_cnt == IH-1) && (col_cnt == IW-1);
                  pending_results.push_back(r);
               end
            end
            col_cnt++;
            if (col_cnt >= IW) begin
               col_cnt = 0;
               row_cnt = (row_cnt + 1 >= IH) ? 0 : row_cnt + 1;
            end
         end
         default: ;   // unused command, no effect
      endcase
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      err_count++;
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
   endtask

   // ---- result checker ----
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, out_filter", rsp.data.out_filter, -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp.data.out_filter != want.out_filter)
               report_mismatch("out_filter", rsp.data.out_filter, want.out_filter);
            if (rsp.data.out_row != want.out_row)
               report_mismatch("out_row", rsp.data.out_row, want.out_row);
            if (rsp.data.out_col != want.out_col)
               report_mismatch("out_col", rsp.data.out_col, want.out_col);
            if (rsp.data.conv_value !== want.conv_value)
               report_mismatch("conv_value", rsp.data.conv_value, want.conv_value);
            if (rsp.data.last_filter !== want.last_filter)
               report_mismatch("last_filter", rsp.data.last_filter, want.last_filter);
            if (rsp.data.last_of_image !== want.last_of_image)
               report_mismatch("last_of_image", rsp.data.last_of_image, want.last_of_image);
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock)
      rsp.ready <= ($urandom_range(99) >= rsp_stall);

   // Watchdog: cycles without any transfer on either channel.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCH_LIMIT) begin
         $display("multichannel_conv2d_layer_tb: errors");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // ---- stimulus helpers ----
   task automatic send_item(input req_type it);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data  <= it;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      conv_model_step(it);
   endtask

   // Pause the sender until every queued result has been taken.
   task automatic drain;
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_shift(input logic [4:0] val);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      shift_amt  = val;
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // All fields random; the command and its key fields then set.
   function automatic req_type rand_item(input cmd_type c);
      req_type    it;
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      it  = raw[$bits(req_type)-1:0];
      it.cmd          = c;
      it.weight_value = rand_sample();
      it.pix_c0       = rand_sample();
      it.pix_c1       = rand_sample();
      it.pix_c2       = rand_sample();
      if (c == CMD_WEIGHT && $urandom_range(9) != 0) begin
         it.chan_idx = 2'($urandom_range(CH-1));
         it.tap_row  = 3'($urandom_range(K-1));
         it.tap_col  = 3'($urandom_range(K-1));
      end
      return it;
   endfunction

   // ---- tests ----
   // Every weight and bias gets a value before any window completes.
   task automatic test_load_stores;
      req_type it;
      for (int f = 0; f < NF; f++) begin
         it = rand_item(CMD_BIAS);
         it.filter_idx = 5'(f);
         send_item(it);
         for (int c = 0; c < CH; c++)
            for (int y = 0; y < K; y++)
               for (int x = 0; x < K; x++) begin
                  it = rand_item(CMD_WEIGHT);
                  it.filter_idx = 5'(f);
                  it.chan_idx   = 2'(c);
                  it.tap_row    = 3'(y);
                  it.tap_col    = 3'(x);
                  send_item(it);
               end
      end
   endtask

   // Extremes, ignored commands and out-of-range loads.
   task automatic test_directed;
      req_type it;
      it = rand_item(CMD_NONE);
      send_item(it);
      it = rand_item(CMD_WEIGHT); it.chan_idx = 2'd3; send_item(it);
      it = rand_item(CMD_WEIGHT); it.chan_idx = 2'd0; it.tap_row = 3'd5; send_item(it);
      it = rand_item(CMD_WEIGHT); it.chan_idx = 2'd1; it.tap_row = 3'd0;
      it.tap_col = 3'd7; send_item(it);
      it = rand_item(CMD_WEIGHT); it.filter_idx = 5'd31; it.chan_idx = 2'd2;
      it.tap_row = 3'd4; it.tap_col = 3'd4; it.weight_value = 16'sh8000; send_item(it);
      it = rand_item(CMD_WEIGHT); it.filter_idx = 5'd0; it.chan_idx = 2'd0;
      it.tap_row = 3'd0; it.tap_col = 3'd0; it.weight_value = 16'sh7fff; send_item(it);
      it = rand_item(CMD_BIAS); it.filter_idx = 5'd0;
      it.bias_value = 32'sh7fffffff; send_item(it);
      it = rand_item(CMD_BIAS); it.filter_idx = 5'd31;
      it.bias_value = 32'sh80000000; send_item(it);
      for (int i = 0; i < 12; i++) begin
         it = rand_item(CMD_PIXEL);
         it.pix_c0 = (i % 2) ? 16'sh7fff : 16'sh8000;
         it.pix_c1 = (i % 3) ? 16'sh8000 : 16'sh7fff;
         it.pix_c2 = (i % 4) ? 16'sh0000 : 16'shffff;
         send_item(it);
         if (i == 5) begin   // load between pixels
            it = rand_item(CMD_BIAS); it.filter_idx = 5'd7; send_item(it);
         end
      end
   endtask

   // Mostly pixels with loads mixed in, a little noise.
   task automatic test_random_traffic(input int n_items);
      int pick;
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(99);
         if (pick < 72)      send_item(rand_item(CMD_PIXEL));
         else if (pick < 88) send_item(rand_item(CMD_WEIGHT));
         else if (pick < 96) send_item(rand_item(CMD_BIAS));
         else                send_item(rand_item(CMD_NONE));
      end
   endtask

   task automatic set_idling(input int s_idle, input int r_stall);
      send_idle = s_idle;
      rsp_stall = r_stall;
   endtask

   initial begin
      foreach (line_mem[y, x, c]) line_mem[y][x][c] = '0;
      foreach (win[y, x, c]) win[y][x][c] = '0;
      row_cnt   = 0;
      col_cnt   = 0;
      shift_amt = SHIFT_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // windows first complete in the later phases, so the stalling
      // receiver and the saturating shift are placed there
      set_idling(0, 0);
      test_load_stores();
      test_directed();
      test_random_traffic(75);
      write_shift(5'd31);
      set_idling(65, 0);
      test_random_traffic(75);
      write_shift(5'd0);             // saturation both ways
      set_idling(14, 14);
      test_random_traffic(75);
      write_shift(5'($urandom_range(1, 30)));
      set_idling(0, 65);
      test_random_traffic(80);

      drain();
      if (err_count == 0)
         $display("multichannel_conv2d_layer_tb: clean");
      else
         $display("multichannel_conv2d_layer_tb: errors");
      $finish;
   end
endmodule
